[rtl/mur2_pkg.sv]
// shared types, constants and the mixing multiply for the murmur2 64b hash block
// no dependencies; compiled first
package mur2_pkg;

    // mixing constant and shift amounts of the hash
    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam int unsigned FIN_SHIFT_1 = 18;
    localparam int unsigned FIN_SHIFT_2 = 22;
    localparam int unsigned FIN_SHIFT_3 = 17;
    localparam int unsigned FIN_SHIFT_4 = 19;

    // default depth of the queue between front and back
    localparam int unsigned DEF_QUEUE_DEPTH = 2;

    // word class decided by the front
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PART,
        KIND_FULL
    } t_kind;

    // one queued operation
    typedef struct packed {
        t_kind       kind;
        logic        first;
        logic        last;
        logic [31:0] data;
        logic [31:0] seed_one;
    } t_op;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WORD_MIX,
        ST_WORD_LANE,
        ST_PART_MUL,
        ST_FIN_1,
        ST_FIN_2,
        ST_FIN_3,
        ST_FIN_4
    } t_state;

    // low 32 bits of a times the mixing constant
    function automatic logic [31:0] mul_mix(input logic [31:0] a);
        logic [63:0] prod;
        prod = {32'd0, a} * {32'd0, MIX_MUL};
        return prod[31:0];
    endfunction

endpackage

[rtl/mur2_in_if.sv]
// input channel of the murmur2 hash block: one message word per handshake
// no dependencies
interface mur2_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        first_word;
    logic [31:0] message_length;
    logic        last_word;

    modport source (output valid, data_word, valid_bytes, first_word,
                    message_length, last_word, input ready);
    modport sink   (input valid, data_word, valid_bytes, first_word,
                    message_length, last_word, output ready);
endinterface

[rtl/mur2_out_if.sv]
// result channel of the murmur2 hash block: one hash per handshake
// no dependencies
interface mur2_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

[rtl/murmur2_64b_hash.sv]
// MurmurHash2 64b over 32-bit words: front classifier, word queue, mixing back end
// a last full word goes through the queue, the pop with first mix, word mix, lane step and
// final mix steps into the output register; one shared 32-bit constant multiplier serves
// every step, so the back end pops a new word only once the steps of the last one are done
// input is taken while the queue has room, also while a hash waits in the output register
// synchronous active-low reset clears seed, lanes, queue and sequencer; lanes reset to zero
module murmur2_64b_hash import mur2_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    mur2_in_if.sink     i_in,
    mur2_out_if.source  o_out
);

    logic [63:0] r_hash_seed;
    logic        w_push;
    t_op         w_push_op;
    logic        w_full;
    logic        w_pop;
    t_op         w_head;
    logic        w_empty;

    // seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_seed <= 64'd0;
        end else if (i_cfg_wr_en) begin
            r_hash_seed <= i_cfg_wr_data;
        end
    end

    mur2_front u_front (
        .i_seed_lo (r_hash_seed[31:0]),
        .i_in      (i_in),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_push_op (w_push_op)
    );

    mur2_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_push_op (w_push_op),
        .o_full    (w_full),
        .i_pop     (w_pop),
        .o_head    (w_head),
        .o_empty   (w_empty)
    );

    mur2_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seed_hi (r_hash_seed[63:32]),
        .i_q_empty (w_empty),
        .i_q_head  (w_head),
        .o_q_pop   (w_pop),
        .o_out     (o_out)
    );

endmodule

[rtl/mur2_front.sv]
// front end: accepts words, classifies them and masks partial bytes
// depends on mur2_pkg and mur2_in_if
module mur2_front import mur2_pkg::*; (
    input  logic [31:0] i_seed_lo,
    mur2_in_if.sink     i_in,
    input  logic        i_full,
    output logic        o_push,
    output t_op         o_push_op
);

    logic [31:0] w_mask;

    // accept whenever the queue has room
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // byte mask for a partial word
    always_comb begin
        case (i_in.valid_bytes)
            3'd1:    w_mask = 32'h0000_00ff;
            3'd2:    w_mask = 32'h0000_ffff;
            3'd3:    w_mask = 32'h00ff_ffff;
            default: w_mask = 32'h0000_0000;
        endcase
    end

    // classify the word and prepare the lane one seed
    always_comb begin
        o_push_op.first    = i_in.first_word;
        o_push_op.last     = i_in.last_word;
        o_push_op.seed_one = i_seed_lo ^ i_in.message_length;
        if (i_in.valid_bytes inside {[3'd4:3'd7]}) begin
            o_push_op.kind = KIND_FULL;
            o_push_op.data = i_in.data_word;
        end else if (i_in.valid_bytes == 3'd0) begin
            o_push_op.kind = KIND_NONE;
            o_push_op.data = 32'd0;
        end else begin
            o_push_op.kind = KIND_PART;
            o_push_op.data = i_in.data_word & w_mask;
        end
    end

endmodule

[rtl/mur2_queue.sv]
// short queue of classified words between front and back
// depends on mur2_pkg
module mur2_queue import mur2_pkg::*; #(
    parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_push_op,
    output logic o_full,
    input  logic i_pop,
    output t_op  o_head,
    output logic o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_op              r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    // pointer wrap
    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_op;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/mur2_back.sv]
// back end: lane mixing and final mix over one shared constant multiplier
// depends on mur2_pkg and mur2_out_if
module mur2_back import mur2_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_seed_hi,
    input  logic        i_q_empty,
    input  t_op         i_q_head,
    output logic        o_q_pop,
    mur2_out_if.source  o_out
);

    t_state      r_state;
    t_state      n_state;
    logic [31:0] r_lane_one;
    logic [31:0] r_lane_two;
    logic        r_odd;
    logic        r_cur_last;
    logic [31:0] r_prod;
    logic        r_out_valid;
    logic [63:0] r_out_data;

    logic [31:0] w_mul_a;
    logic [31:0] w_mul_p;
    logic        w_out_load;
    logic [31:0] w_lane_two_base;

    assign o_out.valid      = r_out_valid;
    assign o_out.hash_value = r_out_data;

    // multiplier operand per step
    always_comb begin
        case (r_state)
            ST_IDLE:      w_mul_a = i_q_head.data;
            ST_WORD_MIX:  w_mul_a = r_prod ^ (r_prod >> MIX_SHIFT);
            ST_WORD_LANE: w_mul_a = r_odd ? r_lane_two : r_lane_one;
            ST_PART_MUL:  w_mul_a = r_lane_two;
            ST_FIN_1:     w_mul_a = r_lane_one ^ (r_lane_two >> FIN_SHIFT_1);
            ST_FIN_2:     w_mul_a = r_lane_two ^ (r_lane_one >> FIN_SHIFT_2);
            ST_FIN_3:     w_mul_a = r_lane_one ^ (r_lane_two >> FIN_SHIFT_3);
            ST_FIN_4:     w_mul_a = r_lane_two ^ (r_lane_one >> FIN_SHIFT_4);
            default:      w_mul_a = 32'd0;
        endcase
    end

    assign w_mul_p = mul_mix(w_mul_a);

    // sequencer outputs
    always_comb begin
        o_q_pop    = (r_state == ST_IDLE) && !i_q_empty;
        w_out_load = (r_state == ST_FIN_4) && (!r_out_valid || o_out.ready);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    case (i_q_head.kind)
                        KIND_FULL: n_state = ST_WORD_MIX;
                        KIND_PART: n_state = ST_PART_MUL;
                        default:   n_state = i_q_head.last ? ST_FIN_1 : ST_IDLE;
                    endcase
                end
            end
            ST_WORD_MIX:  n_state = ST_WORD_LANE;
            ST_WORD_LANE: n_state = r_cur_last ? ST_FIN_1 : ST_IDLE;
            ST_PART_MUL:  n_state = r_cur_last ? ST_FIN_1 : ST_IDLE;
            ST_FIN_1:     n_state = ST_FIN_2;
            ST_FIN_2:     n_state = ST_FIN_3;
            ST_FIN_3:     n_state = ST_FIN_4;
            ST_FIN_4:     n_state = w_out_load ? ST_IDLE : ST_FIN_4;
            default:      n_state = ST_IDLE;
        endcase
    end

    // lane two after seeding on a first word
    assign w_lane_two_base = i_q_head.first ? i_seed_hi : r_lane_two;

    // control state and lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lane_one  <= 32'd0;
            r_lane_two  <= 32'd0;
            r_odd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (o_q_pop) begin
                        if (i_q_head.first) begin
                            r_lane_one <= i_q_head.seed_one;
                            r_odd      <= 1'b0;
                        end
                        r_lane_two <= w_lane_two_base ^
                                      ((i_q_head.kind == KIND_PART) ? i_q_head.data : 32'd0);
                    end
                end
                ST_WORD_LANE: begin
                    if (r_odd) begin
                        r_lane_two <= w_mul_p ^ r_prod;
                    end else begin
                        r_lane_one <= w_mul_p ^ r_prod;
                    end
                    r_odd <= !r_odd;
                end
                ST_PART_MUL: r_lane_two <= w_mul_p;
                ST_FIN_1:    r_lane_one <= w_mul_p;
                ST_FIN_2:    r_lane_two <= w_mul_p;
                ST_FIN_3:    r_lane_one <= w_mul_p;
                ST_FIN_4: begin
                    if (w_out_load) begin
                        r_lane_two <= w_mul_p;
                        r_odd      <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
            // result register
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // product register, last word flag and result word
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur_last <= i_q_head.last;
        end
        if ((r_state == ST_IDLE) || (r_state == ST_WORD_MIX)) begin
            r_prod <= w_mul_p;
        end
        if (w_out_load) begin
            r_out_data <= {r_lane_one, w_mul_p};
        end
    end

    // no pop from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> !i_q_empty)
        else $error("pop from empty queue");

    // sequencer leaves idle only with a popped word
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !o_q_pop) |=> (r_state == ST_IDLE))
        else $error("left idle without a word");

    // a loaded result shows up and the lane alternation restarts
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (o_out.valid && !r_odd && r_state == ST_IDLE))
        else $error("result not presented after final mix");

    // final mix never starts while a word step is pending
    a_fin_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN_1) |-> ($past(r_state) == ST_IDLE ||
                                   $past(r_state) == ST_WORD_LANE ||
                                   $past(r_state) == ST_PART_MUL))
        else $error("final mix entered from a bad step");

endmodule

[tb/testbench.sv]
// self-checking testbench for murmur2_64b_hash: message words in, 64-bit hashes out
// depends on mur2_pkg, mur2_in_if, mur2_out_if and the rtl top level
`timescale 1ns / 1ps

module testbench import mur2_pkg::*; ();

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 40;
    localparam int unsigned ITEM_TOTAL     = 900;
    localparam int unsigned PHASE_COUNT    = 5;

    // running hash of the message stream and the hashes still owed by the block
    class murmur_scoreboard;
        logic [63:0] seed;
        logic [31:0] lane_one;
        logic [31:0] lane_two;
        bit          odd_next;
        logic [63:0] expected_hashes[$];
        int unsigned errors;

        function new();
            seed     = '0;
            lane_one = '0;
            lane_two = '0;
            odd_next = 1'b0;
            errors   = 0;
        endfunction

        function void set_seed(logic [63:0] value);
            seed = value;
        endfunction

        // low half of the product with the mixing constant
        function logic [31:0] times_m(logic [31:0] a);
            logic [31:0] prod;
            prod = a * MIX_MUL;
            return prod;
        endfunction

        function void note_word(logic [31:0] data, logic [2:0] nbytes, logic is_first,
                                logic [31:0] msg_len, logic is_last);
            logic [31:0] k;
            logic [31:0] mask;
            if (is_first) begin
                lane_one = seed[31:0] ^ msg_len;
                lane_two = seed[63:32];
                odd_next = 1'b0;
            end
            // full word goes to the lane whose turn it is
            if (nbytes >= 3'd4) begin
                k = times_m(data);
                k = k ^ (k >> MIX_SHIFT);
                k = times_m(k);
                if (!odd_next)
                    lane_one = times_m(lane_one) ^ k;
                else
                    lane_two = times_m(lane_two) ^ k;
                odd_next = ~odd_next;
            end else if (nbytes != 3'd0) begin
                case (nbytes)
                    3'd1: mask = 32'h0000_00ff;
                    3'd2: mask = 32'h0000_ffff;
                    default: mask = 32'h00ff_ffff;
                endcase
                lane_two = times_m(lane_two ^ (data & mask));
            end
            if (!is_last)
                return;
            // final mix
            lane_one = times_m(lane_one ^ (lane_two >> FIN_SHIFT_1));
            lane_two = times_m(lane_two ^ (lane_one >> FIN_SHIFT_2));
            lane_one = times_m(lane_one ^ (lane_two >> FIN_SHIFT_3));
            lane_two = times_m(lane_two ^ (lane_one >> FIN_SHIFT_4));
            odd_next = 1'b0;
            expected_hashes.push_back({lane_one, lane_two});
        endfunction

        function void check_hash(logic [63:0] got);
            logic [63:0] want;
            if (expected_hashes.size() == 0) begin
                $error("hash_value: expected none, actual %h", got);
                errors++;
                return;
            end
            want = expected_hashes.pop_front();
            if (got !== want) begin
                $error("hash_value: expected %h, actual %h", want, got);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_hashes.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [63:0] cfg_wr_data = '0;
    logic        sink_ready = 1'b0;
    int unsigned ready_hold = 0;
    bit          sink_stalls = 1'b0;
    bit          src_gaps = 1'b0;
    bit          word_offered = 1'b0;
    int unsigned items_sent = 0;
    int unsigned quiet_cycles = 0;

    murmur_scoreboard sb = new();

    mur2_in_if  in_if();
    mur2_out_if out_if();

    murmur2_64b_hash i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    assign out_if.ready = sink_ready;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short stalls, now and then a long one
    function automatic int unsigned stall_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (!sink_ready || !sink_stalls) begin
            sink_ready <= 1'b1;
            ready_hold <= $urandom_range(0, 15);
        end else begin
            sink_ready <= 1'b0;
            ready_hold <= stall_len() - 1;
        end
    end

    // accepted words and hashes, plus the watchdog
    always @(posedge i_clk) begin
        quiet_cycles = quiet_cycles + 1;
        if (in_if.valid && in_if.ready) begin
            sb.note_word(in_if.data_word, in_if.valid_bytes, in_if.first_word,
                         in_if.message_length, in_if.last_word);
            quiet_cycles = 0;
        end
        if (out_if.valid && out_if.ready) begin
            sb.check_hash(out_if.hash_value);
            quiet_cycles = 0;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // offer one word and hold it until taken, then maybe idle
    task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
                             input logic is_first, input logic [31:0] msg_len,
                             input logic is_last);
        int unsigned gap;
        in_if.valid          <= 1'b1;
        in_if.data_word      <= data;
        in_if.valid_bytes    <= nbytes;
        in_if.first_word     <= is_first;
        in_if.message_length <= msg_len;
        in_if.last_word      <= is_last;
        word_offered = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
        gap = (src_gaps && $urandom_range(0, 1)) ? stall_len() : 0;
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            word_offered = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drop valid and wait until every hash is back and the block has gone quiet
    task automatic settle();
        if (word_offered) begin
            in_if.valid <= 1'b0;
            word_offered = 1'b0;
        end
        // let the monitor note the last accepted word first
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [63:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        sb.set_seed(value);
    endtask

    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return $urandom_range(0, 3);
        if (r < 75)
            return $urandom_range(4, 32);
        if (r < 95)
            return $urandom_range(33, 80);
        return $urandom_range(81, 200);
    endfunction

    // one message split into words; an incomplete one may stop early and has no last word
    task automatic send_message(input int unsigned byte_count, input bit complete);
        int unsigned full_words;
        int unsigned tail;
        int unsigned nwords;
        int unsigned cut;
        logic [31:0] len_field;
        logic [2:0]  nbytes;
        full_words = byte_count / 4;
        tail       = byte_count % 4;
        nwords     = full_words + (tail != 0);
        if (nwords == 0)
            nwords = 1;
        len_field = byte_count;
        if ($urandom_range(0, 9) == 0)
            len_field = $urandom;
        cut = complete ? nwords : $urandom_range(1, nwords);
        for (int i = 0; i < cut; i++) begin
            if (i < full_words)
                nbytes = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'd4;
            else
                nbytes = 3'(tail);
            send_word($urandom, nbytes, i == 0, len_field, complete && (i == nwords - 1));
        end
    endtask

    // mostly well-formed messages, some cut short, some loose words
    task automatic run_phase(input int unsigned item_goal);
        int unsigned pick;
        while (items_sent < item_goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                send_message(pick_length(), 1'b1);
            else if (pick < 90)
                send_message(pick_length(), 1'b0);
            else
                repeat ($urandom_range(1, 4))
                    send_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                              $urandom, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 49) == 0)
                settle();
        end
    endtask

    initial begin
        logic [63:0] phase_seed;
        in_if.valid          <= 1'b0;
        in_if.data_word      <= '0;
        in_if.valid_bytes    <= '0;
        in_if.first_word     <= 1'b0;
        in_if.message_length <= '0;
        in_if.last_word      <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words with the reset seed
        // word with no first word right after reset, lanes start at zero
        send_word(32'hffff_ffff, 3'd4, 1'b0, 32'd0, 1'b1);
        // empty message
        send_word(32'hdead_beef, 3'd0, 1'b1, 32'd0, 1'b1);
        // one and three byte messages, bytes past the count are junk
        send_word(32'hffff_ffff, 3'd1, 1'b1, 32'd1, 1'b1);
        send_word(32'ha5a5_a5a5, 3'd3, 1'b1, 32'd3, 1'b1);
        send_word(32'hffff_ffff, 3'd4, 1'b1, 32'd4, 1'b1);
        // two full words, one per lane
        send_word(32'h0000_0000, 3'd4, 1'b1, 32'd8, 1'b0);
        send_word(32'hffff_ffff, 3'd4, 1'b0, 32'd8, 1'b1);
        // byte counts above four act as full words
        send_word(32'h1234_5678, 3'd5, 1'b1, 32'd4, 1'b1);
        send_word(32'h8765_4321, 3'd6, 1'b1, 32'd4, 1'b1);
        send_word(32'hcafe_f00d, 3'd7, 1'b1, 32'd4, 1'b1);
        // partial word that is not last, then full words, length off
        send_word(32'h5555_aaaa, 3'd2, 1'b1, 32'd77, 1'b0);
        send_word(32'h0f0f_0f0f, 3'd4, 1'b0, 32'd0, 1'b0);
        send_word(32'hf0f0_f0f0, 3'd4, 1'b0, 32'd0, 1'b1);
        // continuing after a last word without a new first word
        send_word(32'h0123_4567, 3'd4, 1'b0, 32'hffff_ffff, 1'b0);
        send_word(32'h89ab_cdef, 3'd1, 1'b0, 32'hffff_ffff, 1'b1);
        // largest length
        send_word(32'h7fff_ffff, 3'd4, 1'b1, 32'hffff_ffff, 1'b1);
        // first word again in mid message restarts the hash
        send_word(32'h8000_0000, 3'd4, 1'b1, 32'd12, 1'b0);
        send_word(32'h0000_0001, 3'd4, 1'b1, 32'd8, 1'b1);
        settle();

        // random phases, each with its own seed
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: phase_seed = 64'hffff_ffff_ffff_ffff;
                2: phase_seed = 64'h0;
                3: phase_seed = 64'h0000_0000_ffff_ffff;
                default: phase_seed = {$urandom, $urandom};
            endcase
            write_seed(phase_seed);
            src_gaps    <= (p != 0);
            sink_stalls <= (p != 0);
            run_phase(ITEM_TOTAL * (p + 1) / PHASE_COUNT);
            settle();
        end

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
